// ===== rtl/ckre_pkg.sv =====
package ckre_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 2048;
    localparam int BATCH_LIMIT = 2000;

    localparam int CHAN_W  = 8;
    localparam int SIZE_W  = 12;
    localparam int POS_W   = 11;
    localparam int EDGE_W  = 12;
    localparam int COUNT_W = 11;
    localparam int CFG_W   = 12;
    localparam int IDX_W   = 3;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 96;
    localparam int OUT_USER_W = 2;

    localparam logic [SIZE_W-1:0]  MAX_WIDTH_C   = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0]  MAX_HEIGHT_C  = SIZE_W'(MAX_HEIGHT);
    localparam logic [COUNT_W-1:0] BATCH_LIMIT_C = COUNT_W'(BATCH_LIMIT);
    localparam logic [EDGE_W-1:0]  BOX_EMPTY     = '1;
    localparam logic [CHAN_W:0]    CHAN_MAX      = (CHAN_W+1)'(255);

    typedef enum logic [IDX_W-1:0] {
        REG_KEY_RED    = 3'd0,
        REG_KEY_GREEN  = 3'd1,
        REG_KEY_BLUE   = 3'd2,
        REG_TOL_RED    = 3'd3,
        REG_TOL_GREEN  = 3'd4,
        REG_TOL_BLUE   = 3'd5,
        REG_WIDTH      = 3'd6,
        REG_HEIGHT     = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic               run_valid;
        logic [POS_W-1:0]   run_left;
        logic [EDGE_W-1:0]  run_right;
        logic [POS_W-1:0]   run_row;
        logic               batch_end;
        logic [COUNT_W-1:0] batch_count;
        logic [EDGE_W-1:0]  bound_left;
        logic [POS_W-1:0]   bound_top;
        logic [EDGE_W-1:0]  bound_right;
        logic [EDGE_W-1:0]  bound_bottom;
        logic               frame_end;
    } result_t;

    function automatic logic chan_in_key(input logic [CHAN_W-1:0] v,
                                         input logic [CHAN_W-1:0] key,
                                         input logic [CHAN_W-1:0] tol);
        logic [CHAN_W:0] hi;
        hi = {1'b0, key} + {1'b0, tol};
        if (hi > CHAN_MAX) begin
            hi = CHAN_MAX;
        end
        return (v >= key) && ({1'b0, v} <= hi);
    endfunction

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] max);
        if (v == '0) begin
            return SIZE_W'(1);
        end else if (v > max) begin
            return max;
        end
        return v;
    endfunction

endpackage

// ===== rtl/color_key_run_extractor.sv =====
// Colour-key run extractor. Pixels arrive one per item in raster order (s_tdata: red, green,
// blue from bit 0 up); a pixel is transparent when each channel lies in [key, min(255, key+tol)].
// Every closed horizontal run of opaque pixels gives one result item carrying left, exclusive
// right and row, together with the running batch count and bounding box; the last pixel of the
// image always gives a result (m_tlast high), and a batch closes at 2000 runs or at frame end.
// One pixel is taken every clock cycle unless a result must wait on m_tready; each pixel is held
// in the input register and its result in the result register. That rate is set by the run and
// batch bookkeeping, updated once per pixel between them. Configuration must be written through
// cfg_we/cfg_index/cfg_wdata only while no pixel is in flight; the block does not enforce it.
module color_key_run_extractor (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               cfg_we,
    input  logic [ckre_pkg::IDX_W-1:0]         cfg_index,
    input  logic [ckre_pkg::CFG_W-1:0]         cfg_wdata,

    input  logic                               s_tvalid,
    output logic                               s_tready,
    // pixel_red, pixel_green, pixel_blue
    input  logic [ckre_pkg::IN_DATA_W-1:0]     s_tdata,

    output logic                               m_tvalid,
    input  logic                               m_tready,
    // run_left, run_right, run_row, batch_count, bound_left, bound_top, bound_right,
    // bound_bottom, zero padding
    output logic [ckre_pkg::OUT_DATA_W-1:0]    m_tdata,
    // run_valid, batch_end
    output logic [ckre_pkg::OUT_USER_W-1:0]    m_tuser,
    // frame_end
    output logic                               m_tlast
);

    localparam int CW = ckre_pkg::CHAN_W;
    localparam int SW = ckre_pkg::SIZE_W;
    localparam int PW = ckre_pkg::POS_W;
    localparam int EW = ckre_pkg::EDGE_W;
    localparam int NW = ckre_pkg::COUNT_W;

    // configuration
    logic [CW-1:0] key_red_reg, key_green_reg, key_blue_reg;
    logic [CW-1:0] tol_red_reg, tol_green_reg, tol_blue_reg;
    logic [SW-1:0] width_reg, height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_red_reg   <= CW'(255);
            key_green_reg <= '0;
            key_blue_reg  <= CW'(255);
            tol_red_reg   <= '0;
            tol_green_reg <= '0;
            tol_blue_reg  <= '0;
            width_reg     <= ckre_pkg::MAX_WIDTH_C;
            height_reg    <= ckre_pkg::MAX_HEIGHT_C;
        end else if (cfg_we) begin
            unique case (ckre_pkg::reg_index_t'(cfg_index))
                ckre_pkg::REG_KEY_RED:   key_red_reg   <= cfg_wdata[CW-1:0];
                ckre_pkg::REG_KEY_GREEN: key_green_reg <= cfg_wdata[CW-1:0];
                ckre_pkg::REG_KEY_BLUE:  key_blue_reg  <= cfg_wdata[CW-1:0];
                ckre_pkg::REG_TOL_RED:   tol_red_reg   <= cfg_wdata[CW-1:0];
                ckre_pkg::REG_TOL_GREEN: tol_green_reg <= cfg_wdata[CW-1:0];
                ckre_pkg::REG_TOL_BLUE:  tol_blue_reg  <= cfg_wdata[CW-1:0];
                ckre_pkg::REG_WIDTH:     width_reg     <= cfg_wdata[SW-1:0];
                ckre_pkg::REG_HEIGHT:    height_reg    <= cfg_wdata[SW-1:0];
                default: ;
            endcase
        end
    end

    // input register
    logic                              in_valid_reg;
    logic [ckre_pkg::IN_DATA_W-1:0]    in_data_reg;
    logic                              advance;
    logic                              produce;
    logic                              out_free;

    logic              m_valid_reg;
    ckre_pkg::result_t result_reg;
    ckre_pkg::result_t result_next;

    assign out_free = !m_valid_reg || m_tready;
    assign advance  = in_valid_reg && (out_free || !produce);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
        end
    end

    // per-pixel state
    logic [PW-1:0] column_reg, column_next;
    logic [PW-1:0] row_reg, row_next;
    logic          run_open_reg, run_open_next;
    logic [PW-1:0] first_col_reg, first_col_next;
    logic [NW-1:0] runs_reg, runs_next;
    logic [EW-1:0] box_left_reg, box_left_next;
    logic [EW-1:0] box_top_reg, box_top_next;
    logic [EW-1:0] box_right_reg, box_right_next;
    logic [EW-1:0] box_bottom_reg, box_bottom_next;

    logic [SW-1:0] width_eff, height_eff;
    logic          transparent;
    logic          row_end, frame_end;
    logic          emit, batch_end;
    logic [PW-1:0] left;
    logic [EW-1:0] right;
    logic [EW-1:0] row_ext, row_plus;
    logic [SW-1:0] col_plus;
    logic [NW-1:0] runs_emit;
    logic [EW-1:0] bl, bt, br, bb;

    always_comb begin
        width_eff  = ckre_pkg::clamp_size(width_reg, ckre_pkg::MAX_WIDTH_C);
        height_eff = ckre_pkg::clamp_size(height_reg, ckre_pkg::MAX_HEIGHT_C);
        transparent = ckre_pkg::chan_in_key(in_data_reg[CW-1:0], key_red_reg, tol_red_reg)
                   && ckre_pkg::chan_in_key(in_data_reg[2*CW-1:CW], key_green_reg,
                                            tol_green_reg)
                   && ckre_pkg::chan_in_key(in_data_reg[3*CW-1:2*CW], key_blue_reg,
                                            tol_blue_reg);
        col_plus  = {1'b0, column_reg} + SW'(1);
        row_ext   = {1'b0, row_reg};
        row_plus  = row_ext + EW'(1);
        row_end   = col_plus >= width_eff;
        frame_end = row_end && (row_plus >= height_eff);

        emit           = 1'b0;
        left           = first_col_reg;
        right          = {1'b0, column_reg};
        run_open_next  = run_open_reg;
        first_col_next = first_col_reg;
        if (transparent) begin
            emit          = run_open_reg;
            run_open_next = 1'b0;
        end else begin
            if (!run_open_reg) begin
                left           = column_reg;
                first_col_next = column_reg;
            end
            run_open_next = !row_end;
            if (row_end) begin
                emit  = 1'b1;
                right = col_plus;
            end
        end

        // batch bookkeeping, the run joins the box before it is reported
        runs_emit = runs_reg;
        bl = box_left_reg;
        bt = box_top_reg;
        br = box_right_reg;
        bb = box_bottom_reg;
        if (emit) begin
            runs_emit = runs_reg + NW'(1);
            if ({1'b0, left} < bl) bl = {1'b0, left};
            if (row_ext < bt)      bt = row_ext;
            if (right > br)        br = right;
            if (row_plus > bb)     bb = row_plus;
        end
        batch_end = (emit && (runs_emit >= ckre_pkg::BATCH_LIMIT_C)) || frame_end;
        produce   = emit || frame_end;

        result_next.run_valid    = emit;
        result_next.run_left     = emit ? left : '0;
        result_next.run_right    = emit ? right : '0;
        result_next.run_row      = emit ? row_reg : '0;
        result_next.batch_end    = batch_end;
        result_next.batch_count  = runs_emit;
        result_next.bound_left   = (runs_emit != '0) ? bl : '0;
        result_next.bound_top    = (runs_emit != '0) ? bt[PW-1:0] : '0;
        result_next.bound_right  = (runs_emit != '0) ? br : '0;
        result_next.bound_bottom = (runs_emit != '0) ? bb : '0;
        result_next.frame_end    = frame_end;

        if (batch_end) begin
            runs_next       = '0;
            box_left_next   = ckre_pkg::BOX_EMPTY;
            box_top_next    = ckre_pkg::BOX_EMPTY;
            box_right_next  = '0;
            box_bottom_next = '0;
        end else begin
            runs_next       = runs_emit;
            box_left_next   = bl;
            box_top_next    = bt;
            box_right_next  = br;
            box_bottom_next = bb;
        end

        if (frame_end) begin
            run_open_next  = 1'b0;
            first_col_next = '0;
        end

        if (row_end) begin
            column_next = '0;
            row_next    = frame_end ? '0 : row_plus[PW-1:0];
        end else begin
            column_next = col_plus[PW-1:0];
            row_next    = row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg     <= '0;
            row_reg        <= '0;
            run_open_reg   <= 1'b0;
            first_col_reg  <= '0;
            runs_reg       <= '0;
            box_left_reg   <= ckre_pkg::BOX_EMPTY;
            box_top_reg    <= ckre_pkg::BOX_EMPTY;
            box_right_reg  <= '0;
            box_bottom_reg <= '0;
        end else if (advance) begin
            column_reg     <= column_next;
            row_reg        <= row_next;
            run_open_reg   <= run_open_next;
            first_col_reg  <= first_col_next;
            runs_reg       <= runs_next;
            box_left_reg   <= box_left_next;
            box_top_reg    <= box_top_next;
            box_right_reg  <= box_right_next;
            box_bottom_reg <= box_bottom_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && produce) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && produce) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000,
                       result_reg.bound_bottom,
                       result_reg.bound_right,
                       result_reg.bound_top,
                       result_reg.bound_left,
                       result_reg.batch_count,
                       result_reg.run_row,
                       result_reg.run_right,
                       result_reg.run_left};
    assign m_tuser  = {result_reg.batch_end, result_reg.run_valid};
    assign m_tlast  = result_reg.frame_end;

endmodule

// ===== test/tb_top.sv =====
module tb_top;

    localparam int LIMIT_CYCLES  = 200_000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int RANDOM_PIXELS = 480;

    localparam int CW = ckre_pkg::CHAN_W;
    localparam int SW = ckre_pkg::SIZE_W;
    localparam int PW = ckre_pkg::POS_W;
    localparam int EW = ckre_pkg::EDGE_W;
    localparam int NW = ckre_pkg::COUNT_W;
    localparam int IW = ckre_pkg::IN_DATA_W;

    logic                               aclk;
    logic                               aresetn   = 1'b0;
    logic                               cfg_we    = 1'b0;
    logic [ckre_pkg::IDX_W-1:0]         cfg_index = '0;
    logic [ckre_pkg::CFG_W-1:0]         cfg_wdata = '0;
    logic                               s_tvalid  = 1'b0;
    logic                               s_tready;
    // pixel_red, pixel_green, pixel_blue
    logic [IW-1:0]                      s_tdata   = '0;
    logic                               m_tvalid;
    logic                               m_tready  = 1'b0;
    // run_left, run_right, run_row, batch_count, bound_left, bound_top, bound_right,
    // bound_bottom, zero padding
    logic [ckre_pkg::OUT_DATA_W-1:0]    m_tdata;
    // run_valid, batch_end
    logic [ckre_pkg::OUT_USER_W-1:0]    m_tuser;
    // frame_end
    logic                               m_tlast;

    color_key_run_extractor u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // register copies
    logic [CW-1:0] key_c [3] = '{8'd255, 8'd0, 8'd255};
    logic [CW-1:0] tol_c [3] = '{8'd0, 8'd0, 8'd0};
    logic [SW-1:0] width_reg  = 12'd2048;
    logic [SW-1:0] height_reg = 12'd2048;

    // scan and batch state
    int unsigned col_pos    = 0;
    int unsigned row_pos    = 0;
    bit          run_open   = 1'b0;
    int unsigned open_first = 0;
    int unsigned batch_runs = 0;
    int unsigned box_l      = 12'hFFF;
    int unsigned box_t      = 12'hFFF;
    int unsigned box_r      = 0;
    int unsigned box_b      = 0;

    ckre_pkg::result_t due_results [$];
    ckre_pkg::result_t want;
    ckre_pkg::result_t got;
    int unsigned errors      = 0;
    int unsigned cycle_count = 0;
    bit          quiet       = 1'b0;
    int unsigned hold        = 0;
    int unsigned stall       = 0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (quiet) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic bit chan_keyed(int unsigned v, int unsigned key, int unsigned tol);
        int unsigned hi;
        hi = key + tol;
        if (hi > 255) hi = 255;
        return (v >= key) && (v <= hi);
    endfunction

    function automatic int unsigned bounded_size(int unsigned v, int unsigned max);
        if (v < 1) return 1;
        if (v > max) return max;
        return v;
    endfunction

    function automatic logic [IW-1:0] rgb(int unsigned r, int unsigned g, int unsigned b);
        return {b[7:0], g[7:0], r[7:0]};
    endfunction

    // a pixel inside the key window on every channel, or one drawn at random
    function automatic logic [IW-1:0] make_pixel(bit want_keyed);
        logic [CW-1:0] ch [3];
        int unsigned   hi;
        for (int c = 0; c < 3; c++) begin
            if (want_keyed) begin
                hi = key_c[c] + tol_c[c];
                if (hi > 255) hi = 255;
                ch[c] = CW'($urandom_range(hi, key_c[c]));
            end else begin
                ch[c] = CW'($urandom_range(0, 255));
            end
        end
        return {ch[2], ch[1], ch[0]};
    endfunction

    // advances the scan by one pixel and queues the result it gives, if any
    function automatic void track_pixel(logic [IW-1:0] px);
        int unsigned       w, h, col, row, left, right;
        bit                see_through, row_end, frame_end, emit, batch_end;
        ckre_pkg::result_t res;
        w = bounded_size(width_reg, ckre_pkg::MAX_WIDTH);
        h = bounded_size(height_reg, ckre_pkg::MAX_HEIGHT);
        see_through = chan_keyed(px[7:0], key_c[0], tol_c[0]) &&
                      chan_keyed(px[15:8], key_c[1], tol_c[1]) &&
                      chan_keyed(px[23:16], key_c[2], tol_c[2]);
        col = col_pos;
        row = row_pos;
        row_end = (col + 1) >= w;
        frame_end = row_end && ((row + 1) >= h);
        emit = 1'b0;
        left = 0;
        right = 0;
        batch_end = 1'b0;

        if (see_through) begin
            if (run_open) begin
                emit = 1'b1;
                left = open_first;
                right = col;
                run_open = 1'b0;
            end
        end else begin
            if (!run_open) begin
                run_open = 1'b1;
                open_first = col;
            end
            if (row_end) begin
                emit = 1'b1;
                left = open_first;
                right = col + 1;
                run_open = 1'b0;
            end
        end

        if (emit) begin
            batch_runs++;
            if (left < box_l) box_l = left;
            if (row < box_t) box_t = row;
            if (right > box_r) box_r = right;
            if (row + 1 > box_b) box_b = row + 1;
            if (batch_runs >= ckre_pkg::BATCH_LIMIT) batch_end = 1'b1;
        end
        if (frame_end) batch_end = 1'b1;

        if (row_end) begin
            col_pos = 0;
            row_pos = frame_end ? 0 : ((row + 1) & 32'h7FF);
        end else begin
            col_pos = (col + 1) & 32'h7FF;
        end

        if (!emit && !frame_end) return;

        res = '0;
        res.run_valid = emit;
        if (emit) begin
            res.run_left  = PW'(left);
            res.run_right = EW'(right);
            res.run_row   = PW'(row);
        end
        res.batch_end   = batch_end;
        res.batch_count = NW'(batch_runs);
        if (batch_runs != 0) begin
            res.bound_left   = EW'(box_l);
            res.bound_top    = PW'(box_t);
            res.bound_right  = EW'(box_r);
            res.bound_bottom = EW'(box_b);
        end
        res.frame_end = frame_end;
        due_results.push_back(res);

        if (batch_end) begin
            batch_runs = 0;
            box_l = 12'hFFF;
            box_t = 12'hFFF;
            box_r = 0;
            box_b = 0;
        end
        if (frame_end) begin
            run_open = 1'b0;
            open_first = 0;
        end
    endfunction

    task automatic send_pixel(logic [IW-1:0] px);
        int unsigned gap;
        s_tdata  <= px;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        track_pixel(px);
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // block idle: input lowered, every result in, pipeline flushed
    task automatic drain();
        s_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(ckre_pkg::reg_index_t idx, int unsigned value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[ckre_pkg::CFG_W-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            ckre_pkg::REG_KEY_RED:   key_c[0] = value[7:0];
            ckre_pkg::REG_KEY_GREEN: key_c[1] = value[7:0];
            ckre_pkg::REG_KEY_BLUE:  key_c[2] = value[7:0];
            ckre_pkg::REG_TOL_RED:   tol_c[0] = value[7:0];
            ckre_pkg::REG_TOL_GREEN: tol_c[1] = value[7:0];
            ckre_pkg::REG_TOL_BLUE:  tol_c[2] = value[7:0];
            ckre_pkg::REG_WIDTH:     width_reg = value[SW-1:0];
            ckre_pkg::REG_HEIGHT:    height_reg = value[SW-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // reset colour key at the start of a full-width row, then a size change in the middle of it
    task automatic test_reset_defaults();
        for (int i = 0; i < 40; i++) begin
            if (i < 3 || $urandom_range(0, 3) == 0)
                send_pixel(rgb(255, 0, 255));
            else
                send_pixel(IW'($urandom()));
        end
        drain();
        // column 40 already past the new last column, row 0 is the last row
        write_reg(ckre_pkg::REG_WIDTH, 4);
        write_reg(ckre_pkg::REG_HEIGHT, 1);
        send_pixel(rgb(0, 0, 0));
    endtask

    // window edges on each channel, saturation at 255, empty batch, one-pixel frame
    task automatic test_key_edges();
        drain();
        write_reg(ckre_pkg::REG_KEY_RED, 250);
        write_reg(ckre_pkg::REG_KEY_GREEN, 0);
        write_reg(ckre_pkg::REG_KEY_BLUE, 100);
        write_reg(ckre_pkg::REG_TOL_RED, 20);
        write_reg(ckre_pkg::REG_TOL_GREEN, 0);
        write_reg(ckre_pkg::REG_TOL_BLUE, 10);
        write_reg(ckre_pkg::REG_WIDTH, 5);
        write_reg(ckre_pkg::REG_HEIGHT, 3);
        // row 0 all opaque, each pixel just outside the window somewhere
        send_pixel(rgb(0, 0, 0));
        send_pixel(rgb(255, 255, 255));
        send_pixel(rgb(249, 0, 105));
        send_pixel(rgb(255, 1, 105));
        send_pixel(rgb(255, 0, 111));
        // row 1: two runs, the second closed by the row end
        send_pixel(rgb(255, 0, 105));
        send_pixel(rgb(255, 0, 99));
        send_pixel(rgb(0, 0, 0));
        send_pixel(rgb(250, 0, 100));
        send_pixel(rgb(255, 255, 255));
        // row 2 keyed throughout: frame end with no run
        send_pixel(rgb(255, 0, 105));
        send_pixel(rgb(250, 0, 100));
        send_pixel(rgb(250, 0, 110));
        send_pixel(rgb(250, 0, 100));
        send_pixel(rgb(255, 0, 105));
        drain();
        write_reg(ckre_pkg::REG_WIDTH, 2);
        write_reg(ckre_pkg::REG_HEIGHT, 1);
        send_pixel(rgb(250, 0, 110));
        send_pixel(rgb(255, 0, 105));
        drain();
        write_reg(ckre_pkg::REG_WIDTH, 1);
        send_pixel(rgb(255, 255, 255));
    endtask

    // zero width reads as one pixel per row, an oversized height as the maximum
    task automatic test_size_clamp();
        drain();
        write_reg(ckre_pkg::REG_WIDTH, 0);
        write_reg(ckre_pkg::REG_HEIGHT, 12'hFFF);
        repeat (20) send_pixel(make_pixel($urandom_range(0, 2) == 0));
        drain();
        // zero height reads as one row, so the next row end closes the frame
        write_reg(ckre_pkg::REG_HEIGHT, 0);
        send_pixel(make_pixel(1'b0));
    endtask

    task automatic test_random();
        int unsigned sent, w, h, total, clear_pct, k, t;
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            drain();
            quiet = ($urandom_range(0, 4) == 0);
            for (int c = 0; c < 3; c++) begin
                case ($urandom_range(0, 5))
                    0: k = 0;
                    1: k = 255;
                    default: k = $urandom_range(0, 255);
                endcase
                case ($urandom_range(0, 5))
                    0: t = 0;
                    1: t = 255;
                    default: t = $urandom_range(0, 40);
                endcase
                // upper bits of the write word are don't-care for the 8 bit registers
                write_reg(ckre_pkg::reg_index_t'(int'(ckre_pkg::REG_KEY_RED) + c),
                          k | ($urandom_range(0, 15) << 8));
                write_reg(ckre_pkg::reg_index_t'(int'(ckre_pkg::REG_TOL_RED) + c),
                          t | ($urandom_range(0, 15) << 8));
            end
            if ($urandom_range(0, 7) == 0) begin
                w = $urandom_range(9, 64);
                h = $urandom_range(1, 2);
            end else begin
                w = $urandom_range(1, 8);
                h = $urandom_range(1, 5);
            end
            write_reg(ckre_pkg::REG_WIDTH, w);
            write_reg(ckre_pkg::REG_HEIGHT, h);
            total = w * h * $urandom_range(1, 3);
            // sometimes stop part way through a frame
            if ($urandom_range(0, 5) == 0) total += $urandom_range(1, w * h);
            if (total > RANDOM_PIXELS - sent) total = RANDOM_PIXELS - sent;
            clear_pct = $urandom_range(5, 70);
            repeat (total) send_pixel(make_pixel($urandom_range(0, 99) < clear_pct));
            sent += total;
        end
        quiet = 1'b0;
    endtask

    // receiver back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold <= 0;
        end else if (hold != 0) begin
            hold <= hold - 1;
        end else if (m_tready) begin
            stall = pick_gap();
            if (stall != 0) begin
                m_tready <= 1'b0;
                hold <= stall - 1;
            end else begin
                hold <= $urandom_range(0, 4);
            end
        end else begin
            m_tready <= 1'b1;
            hold <= $urandom_range(0, 4);
        end
    end

    function automatic void match_field(string name, int unsigned exp, int unsigned act);
        if (exp != act) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp, act);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (due_results.size() == 0) begin
                $error("result item with nothing expected");
                errors++;
            end else begin
                want = due_results.pop_front();
                got.run_left     = m_tdata[10:0];
                got.run_right    = m_tdata[22:11];
                got.run_row      = m_tdata[33:23];
                got.batch_count  = m_tdata[44:34];
                got.bound_left   = m_tdata[56:45];
                got.bound_top    = m_tdata[67:57];
                got.bound_right  = m_tdata[79:68];
                got.bound_bottom = m_tdata[91:80];
                got.run_valid    = m_tuser[0];
                got.batch_end    = m_tuser[1];
                got.frame_end    = m_tlast;
                match_field("run_valid", want.run_valid, got.run_valid);
                match_field("run_left", want.run_left, got.run_left);
                match_field("run_right", want.run_right, got.run_right);
                match_field("run_row", want.run_row, got.run_row);
                match_field("batch_end", want.batch_end, got.batch_end);
                match_field("batch_count", want.batch_count, got.batch_count);
                match_field("bound_left", want.bound_left, got.bound_left);
                match_field("bound_top", want.bound_top, got.bound_top);
                match_field("bound_right", want.bound_right, got.bound_right);
                match_field("bound_bottom", want.bound_bottom, got.bound_bottom);
                match_field("frame_end", want.frame_end, got.frame_end);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_key_edges();
        test_size_clamp();
        test_random();
        drain();
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
